// ===== design/nm32_pkg.sv =====
// Shared constants, step codes and helper functions for the nimber multiplier.
package nm32_pkg;

  localparam int DEF_OPERAND_WIDTH = 32;
  localparam int MAX_FIELD_LEN     = 64;
  localparam int PORT_WIDTH        = 32;
  localparam int STEP_W            = 2;

  localparam logic [STEP_W-1:0] STEP_LO  = 2'd0;
  localparam logic [STEP_W-1:0] STEP_HI  = 2'd1;
  localparam logic [STEP_W-1:0] STEP_MID = 2'd2;
  localparam logic [STEP_W-1:0] STEP_FIX = 2'd3;

  function automatic int field_len(input int w);
    int len;
    len = 1;
    for (int i = 0; i < 7; i++) begin
      if (len < w && len < MAX_FIELD_LEN) begin
        len = len * 2;
      end
    end
    return len;
  endfunction

  function automatic int eff_width(input int w);
    return (w > MAX_FIELD_LEN) ? MAX_FIELD_LEN : w;
  endfunction

endpackage

// ===== design/nm32_unit.sv =====
// Shared half-width nim multiplier, built by recursive halving down to single bits.
module nm32_unit #(
  parameter int LEN = 16
) (
  input  logic [LEN-1:0] a_i,
  input  logic [LEN-1:0] b_i,
  output logic [LEN-1:0] p_o
);

  if (LEN <= 1) begin : g_leaf
    assign p_o = a_i & b_i;
  end else begin : g_node
    localparam int H = LEN / 2;
    localparam logic [H-1:0] HALF_FERMAT = H'(1) << (H - 1);

    logic [H-1:0] p_lo, p_hi, p_x, p_fix;

    nm32_unit #(.LEN(H)) u_lo (.a_i(a_i[H-1:0]), .b_i(b_i[H-1:0]), .p_o(p_lo));
    nm32_unit #(.LEN(H)) u_hi (.a_i(a_i[LEN-1:H]), .b_i(b_i[LEN-1:H]), .p_o(p_hi));
    nm32_unit #(.LEN(H)) u_x (
      .a_i(a_i[H-1:0] ^ a_i[LEN-1:H]),
      .b_i(b_i[H-1:0] ^ b_i[LEN-1:H]),
      .p_o(p_x)
    );
    nm32_unit #(.LEN(H)) u_fix (.a_i(p_hi), .b_i(HALF_FERMAT), .p_o(p_fix));

    assign p_o = {p_x ^ p_lo, p_lo ^ p_fix};
  end

endmodule

// ===== design/nimber_multiplier_32_core.sv =====
// Top level of the nimber multiplier: operand registers, four-step sequencer, output register.
// Each beat returns the nim product (multiplication in GF(2^L), addition is XOR) of its two
// operands, reduced to OPERAND_WIDTH bits and at most the 32-bit port. One half-width nim
// multiplier is reused over four Karatsuba-style steps (low, high, cross, reduction by the
// Fermat square); the result is loaded into the output register in the reduction step. The
// input stalls while a beat is in the unit or its result is still held, so no new beat is
// accepted until the previous result has been taken.
module nimber_multiplier_32_core #(
  parameter int OPERAND_WIDTH = nm32_pkg::DEF_OPERAND_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [nm32_pkg::PORT_WIDTH-1:0]    left_operand_i,
  input  logic [nm32_pkg::PORT_WIDTH-1:0]    right_operand_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [nm32_pkg::PORT_WIDTH-1:0]    nim_product_o
);
  import nm32_pkg::*;

  localparam int L = field_len(OPERAND_WIDTH);
  localparam int H = L / 2;
  localparam int W = eff_width(OPERAND_WIDTH);
  localparam logic [63:0] MASK64 = (W >= 64) ? {64{1'b1}} : ((64'd1 << W) - 64'd1);
  localparam logic [H-1:0] HALF_FERMAT = H'(1) << (H - 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic [L-1:0]      a_q, b_q;
  logic [H-1:0]      plo_q, phi_q, mid_q;
  logic [PORT_WIDTH-1:0] res_q;
  logic [H-1:0]      ua, ub, up;
  logic [63:0]       a64, b64, full;
  logic              in_acc, out_acc;

  assign in_stall_o    = busy_q | out_valid_q;
  assign in_acc        = in_valid_i & ~in_stall_o;
  assign out_acc       = out_valid_q & ~out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign nim_product_o = res_q;

  assign a64 = 64'(left_operand_i) & MASK64;
  assign b64 = 64'(right_operand_i) & MASK64;

  always_comb begin
    case (step_q)
      STEP_LO: begin
        ua = a_q[H-1:0];
        ub = b_q[H-1:0];
      end
      STEP_HI: begin
        ua = a_q[L-1:H];
        ub = b_q[L-1:H];
      end
      STEP_MID: begin
        ua = a_q[H-1:0] ^ a_q[L-1:H];
        ub = b_q[H-1:0] ^ b_q[L-1:H];
      end
      default: begin
        ua = phi_q;
        ub = HALF_FERMAT;
      end
    endcase
  end

  nm32_unit #(.LEN(H)) u_unit (.a_i(ua), .b_i(ub), .p_o(up));

  assign full = 64'({mid_q, up ^ plo_q}) & MASK64;

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      busy_d = 1'b1;
      step_d = STEP_LO;
    end else if (busy_q) begin
      step_d = step_q + 1'b1;
      if (step_q == STEP_FIX) begin
        busy_d      = 1'b0;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_LO;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q <= a64[L-1:0];
      b_q <= b64[L-1:0];
    end
    if (busy_q) begin
      case (step_q)
        STEP_LO:  plo_q <= up;
        STEP_HI:  phi_q <= up;
        STEP_MID: mid_q <= up ^ plo_q;
        default:  res_q <= full[PORT_WIDTH-1:0];
      endcase
    end
  end

endmodule

// ===== design/nimber_multiplier_32_checker.sv =====
// Port-level checker for the nimber multiplier, bound to the top level.
module nimber_multiplier_32_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] left_operand_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] nim_product_o
);

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(nim_product_o))
    else $error("stalled result beat dropped or changed");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##5 out_valid_o)
    else $error("result beat missing five cycles after input beat");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !out_valid_o)
    else $error("result appeared too early");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && left_operand_i == 32'd0 |-> ##5 nim_product_o == 32'd0)
    else $error("zero operand gave nonzero product");

endmodule

bind nimber_multiplier_32_core nimber_multiplier_32_checker u_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_stall_o(in_stall_o),
  .left_operand_i(left_operand_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .nim_product_o(nim_product_o)
);
